### src/mwf_pkg.sv
`default_nettype none
package mwf_pkg;

  localparam int MAX_WINDOW_DEF = 5;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int LANES_DEF      = 3;

  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int COL_TAG_W  = 12;
  localparam int PIX_W      = 8;
  localparam int NCH_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NCH   = 3'd4;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_TAG_W-1:0] col;
    logic                 last;
    logic [NCH_W-1:0]     nch;
  } tag_t;

  function automatic logic [2:0] win_radius(input logic [2:0] v, input int maxw);
    int e;
    e = int'(v);
    if (e < 3) e = 3;
    if ((e % 2) == 0) e = e - 1;
    if (e > maxw) e = maxw;
    if ((e % 2) == 0) e = e - 1;
    return 3'(e / 2);
  endfunction

endpackage
`default_nettype wire

### src/mwf_line_store.sv
`default_nettype none
module mwf_line_store import mwf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int LANES      = LANES_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int LW = LANES * PIX_W,
  localparam int EW = (MAX_WINDOW - 1) * LW
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [CW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [CW-1:0] wr_addr_i,
  input  wire logic [LW-1:0] wr_pix_i,
  output logic      [EW-1:0] rd_data_o
);

  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] byp_q;
  logic          hz_q;
  logic [EW-1:0] wr_data;

  assign rd_data_o = hz_q ? byp_q : rd_q;
  assign wr_data   = {rd_data_o[(MAX_WINDOW-2)*LW-1:0], wr_pix_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      hz_q  <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_q <= wr_data;
    end
  end

endmodule
`default_nettype wire

### src/mwf_window.sv
`default_nettype none
module mwf_window import mwf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int LANES      = LANES_DEF,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int LW  = LANES * PIX_W,
  localparam int EW  = (MAX_WINDOW - 1) * LW,
  localparam int MW  = MAX_WINDOW,
  localparam int NV  = MW * MW,
  localparam int KW  = $clog2(NV + 1),
  localparam int IW  = $clog2(MW)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             ld_i,
  input  wire logic [LW-1:0]    pix_i,
  input  wire logic [EW-1:0]    mem_i,
  input  wire logic [ROW_W-1:0] r_i,
  input  wire logic [CW-1:0]    c_i,
  input  wire logic [ROW_W-1:0] h1_i,
  input  wire logic [CW-1:0]    w1_i,
  input  wire logic [2:0]       rh_i,
  input  wire logic [2:0]       rw_i,
  input  wire logic [NCH_W-1:0] nch_i,
  output logic                  free_o,
  output logic                  cand_valid_o,
  output logic [PIX_W-1:0]      cand_val_o [LANES][NV],
  output logic                  cand_act_o [NV],
  output logic [KW-1:0]         cand_k_o,
  output tag_t                  cand_tag_o
);

  logic [PIX_W-1:0] win_q [MW][MW][LANES];
  logic             busy_q;
  logic [ROW_W-1:0] orow_q, rhi_q, pr_q;
  logic [CW-1:0]    ocol_q, clo_q, chi_q, pc_q;
  logic [ROW_W-1:0] rlo, rhi;
  logic [CW-1:0]    clo, chi;
  logic             rany, cany, last;
  logic [IW-1:0]    jj [MW];
  logic [IW-1:0]    kk [MW];
  logic [KW-1:0]    nv;

  assign last   = (orow_q == rhi_q) && (ocol_q == chi_q);
  assign free_o = !busy_q || (en_i && last);
  assign nv     = KW'({rh_i, 1'b1} * {rw_i, 1'b1});

  always_comb begin
    if (r_i == h1_i) begin
      rlo  = (r_i >= ROW_W'(rh_i)) ? r_i - ROW_W'(rh_i) : '0;
      rhi  = r_i;
      rany = 1'b1;
    end else begin
      rlo  = r_i - ROW_W'(rh_i);
      rhi  = rlo;
      rany = r_i >= ROW_W'(rh_i);
    end
    if (c_i == w1_i) begin
      clo  = (c_i >= CW'(rw_i)) ? c_i - CW'(rw_i) : '0;
      chi  = c_i;
      cany = 1'b1;
    end else begin
      clo  = c_i - CW'(rw_i);
      chi  = clo;
      cany = c_i >= CW'(rw_i);
    end
  end

  always_comb begin
    logic [ROW_W:0] s, y;
    logic [CW:0]    sc, x;
    logic [ROW_W:0] jf;
    logic [CW:0]    kf;
    for (int d = 0; d < MW; d++) begin
      s  = {1'b0, orow_q} + (ROW_W + 1)'(d);
      y  = (s >= (ROW_W + 1)'(rh_i)) ? s - (ROW_W + 1)'(rh_i) : '0;
      if (y > {1'b0, h1_i}) y = {1'b0, h1_i};
      jf = ({1'b0, pr_q} >= y) ? {1'b0, pr_q} - y : '0;
      jj[d] = (jf > (ROW_W + 1)'(MW - 1)) ? IW'(MW - 1) : jf[IW-1:0];
      sc = {1'b0, ocol_q} + (CW + 1)'(d);
      x  = (sc >= (CW + 1)'(rw_i)) ? sc - (CW + 1)'(rw_i) : '0;
      if (x > {1'b0, w1_i}) x = {1'b0, w1_i};
      kf = ({1'b0, pc_q} >= x) ? {1'b0, pc_q} - x : '0;
      kk[d] = (kf > (CW + 1)'(MW - 1)) ? IW'(MW - 1) : kf[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      for (int k = MW - 1; k > 0; k--) begin
        win_q[k] <= win_q[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        win_q[0][0][l] <= pix_i[l*PIX_W +: PIX_W];
        for (int j = 1; j < MW; j++) begin
          win_q[0][j][l] <= mem_i[((j - 1) * LANES + l) * PIX_W +: PIX_W];
        end
      end
      orow_q <= rlo;
      rhi_q  <= rhi;
      ocol_q <= clo;
      clo_q  <= clo;
      chi_q  <= chi;
      pr_q   <= r_i;
      pc_q   <= c_i;
    end else if (busy_q && en_i && !last) begin
      if (ocol_q == chi_q) begin
        ocol_q <= clo_q;
        orow_q <= orow_q + 1'b1;
      end else begin
        ocol_q <= ocol_q + 1'b1;
      end
    end
    if (en_i) begin
      for (int dy = 0; dy < MW; dy++) begin
        for (int dx = 0; dx < MW; dx++) begin
          cand_act_o[dy*MW+dx] <= (dy <= 2 * int'(rh_i)) && (dx <= 2 * int'(rw_i));
          for (int l = 0; l < LANES; l++) begin
            cand_val_o[l][dy*MW+dx] <= win_q[kk[dx]][jj[dy]][l];
          end
        end
      end
      cand_k_o        <= nv >> 1;
      cand_tag_o.row  <= orow_q;
      cand_tag_o.col  <= COL_TAG_W'(ocol_q);
      cand_tag_o.last <= last;
      cand_tag_o.nch  <= nch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cand_valid_o <= 1'b0;
    end else begin
      if (ld_i) begin
        busy_q <= rany && cany;
      end else if (busy_q && en_i && last) begin
        busy_q <= 1'b0;
      end
      if (en_i) begin
        cand_valid_o <= busy_q;
      end
    end
  end

endmodule
`default_nettype wire

### src/mwf_bit_cell.sv
`default_nettype none
module mwf_bit_cell import mwf_pkg::*; #(
  parameter int BIT   = 7,
  parameter int LANES = LANES_DEF,
  parameter int NV    = MAX_WINDOW_DEF * MAX_WINDOW_DEF,
  localparam int KW   = $clog2(NV + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [PIX_W-1:0] val_i [LANES][NV],
  input  wire logic             act_i [LANES][NV],
  input  wire logic [KW-1:0]    k_i [LANES],
  input  wire logic [PIX_W-1:0] med_i [LANES],
  input  wire tag_t             tag_i,
  output logic                  valid_o,
  output logic [PIX_W-1:0]      val_o [LANES][NV],
  output logic                  act_o [LANES][NV],
  output logic [KW-1:0]         k_o [LANES],
  output logic [PIX_W-1:0]      med_o [LANES],
  output tag_t                  tag_o
);

  logic [KW-1:0]    z [LANES];
  logic             one [LANES];
  logic [PIX_W-1:0] med_n [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      z[l] = '0;
      for (int n = 0; n < NV; n++) begin
        z[l] = z[l] + KW'(act_i[l][n] && !val_i[l][n][BIT]);
      end
      one[l] = !(k_i[l] < z[l]);
      med_n[l] = med_i[l];
      med_n[l][BIT] = one[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_o <= val_i;
      tag_o <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        for (int n = 0; n < NV; n++) begin
          act_o[l][n] <= act_i[l][n] && (val_i[l][n][BIT] == one[l]);
        end
        k_o[l]   <= one[l] ? k_i[l] - z[l] : k_i[l];
        med_o[l] <= med_n[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

endmodule
`default_nettype wire

### src/median_window_filter_unit.sv
// Path: input, window, candidate, bit-cell and output registers, in that order.
// Throughput: one pixel per cycle unless the output stalls or a pixel
// completes m > 1 windows: its m results, up to 9 for 5x5 windows at the
// frame corner, leave the window register one per cycle while input waits.
// Reset: counters zero, registers 640/480/3/3/1; the line store is not cleared.
`default_nettype none
module median_window_filter_unit import mwf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int LANES      = LANES_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      sample_0_i,
  input  wire logic [PIX_W-1:0]      sample_1_i,
  input  wire logic [PIX_W-1:0]      sample_2_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [ROW_W-1:0]           out_row_o,
  output logic [CW-1:0]              out_col_o,
  output logic [PIX_W-1:0]           median_0_o,
  output logic [PIX_W-1:0]           median_1_o,
  output logic [PIX_W-1:0]           median_2_o,
  output logic                       last_of_run_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LW = LANES * PIX_W;
  localparam int EW = (MAX_WINDOW - 1) * LW;
  localparam int NV = MAX_WINDOW * MAX_WINDOW;
  localparam int KW = $clog2(NV + 1);

  logic [10:0]      img_w_q;
  logic [12:0]      img_h_q;
  logic [2:0]       win_w_q, win_h_q;
  logic [1:0]       nch_q;
  logic [ROW_W-1:0] r_q, r_e, h1;
  logic [CW-1:0]    c_q, c_e, w1;
  logic [NCH_W-1:0] nch;
  logic [2:0]       rh, rw;
  logic             acc, s1_go, free, en;

  logic             p0_valid_q;
  logic [LW-1:0]    p0_pix_q, pix;
  logic [ROW_W-1:0] p0_r_q;
  logic [CW-1:0]    p0_c_q;
  logic [EW-1:0]    mem_data;

  logic             st_valid [9];
  logic [PIX_W-1:0] st_val [9][LANES][NV];
  logic             st_act [9][LANES][NV];
  logic [KW-1:0]    st_k [9][LANES];
  logic [PIX_W-1:0] st_med [9][LANES];
  tag_t             st_tag [9];
  logic             cand_act [NV];
  logic [KW-1:0]    cand_k;

  logic             out_valid_q, sk_valid_q, push, take;
  logic [ROW_W-1:0] out_row_q, sk_row_q;
  logic [CW-1:0]    out_col_q, sk_col_q;
  logic             out_last_q, sk_last_q;
  logic [PIX_W-1:0] out_med_q [LANES];
  logic [PIX_W-1:0] sk_med_q [LANES];
  logic [PIX_W-1:0] new_med [LANES];
  logic [PIX_W-1:0] med_port [3];

  assign cfg_ready_o = 1'b1;
  assign en          = !sk_valid_q;
  assign s1_go       = p0_valid_q && free;
  assign in_stall_o  = p0_valid_q && !s1_go;
  assign acc         = in_valid_i && !in_stall_o;

  always_comb begin
    if (img_w_q == '0) w1 = '0;
    else if (int'(img_w_q) > MAX_WIDTH) w1 = CW'(MAX_WIDTH - 1);
    else w1 = CW'(img_w_q - 11'd1);
    if (img_h_q == '0) h1 = '0;
    else if (int'(img_h_q) > MAX_HEIGHT) h1 = ROW_W'(MAX_HEIGHT - 1);
    else h1 = ROW_W'(img_h_q - 13'd1);
    if (nch_q == '0) nch = NCH_W'(1);
    else if (int'(nch_q) > LANES) nch = NCH_W'(LANES);
    else nch = nch_q;
    rh = win_radius(win_h_q, MAX_WINDOW);
    rw = win_radius(win_w_q, MAX_WINDOW);
    if (r_q > h1 || c_q > w1) begin
      r_e = '0;
      c_e = '0;
    end else begin
      r_e = r_q;
      c_e = c_q;
    end
    for (int l = 0; l < LANES; l++) begin
      case (l)
        0:       pix[l*PIX_W +: PIX_W] = sample_0_i;
        1:       pix[l*PIX_W +: PIX_W] = sample_1_i;
        2:       pix[l*PIX_W +: PIX_W] = sample_2_i;
        default: pix[l*PIX_W +: PIX_W] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= 11'd640;
      img_h_q    <= 13'd480;
      win_w_q    <= 3'd3;
      win_h_q    <= 3'd3;
      nch_q      <= 2'd1;
      r_q        <= '0;
      c_q        <= '0;
      p0_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        p0_valid_q <= 1'b1;
      end else if (s1_go) begin
        p0_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_IMG_W: img_w_q <= cfg_data_i[10:0];
          CFG_IMG_H: img_h_q <= cfg_data_i[12:0];
          CFG_WIN_W: win_w_q <= cfg_data_i[2:0];
          CFG_WIN_H: win_h_q <= cfg_data_i[2:0];
          CFG_NCH:   nch_q   <= cfg_data_i[1:0];
          default: ;
        endcase
        if (cfg_index_i inside {CFG_IMG_W, CFG_IMG_H, CFG_WIN_W, CFG_WIN_H}) begin
          r_q <= '0;
          c_q <= '0;
        end
      end else if (acc) begin
        if (c_e >= w1) begin
          c_q <= '0;
          r_q <= (r_e >= h1) ? '0 : r_e + 1'b1;
        end else begin
          c_q <= c_e + 1'b1;
          r_q <= r_e;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p0_pix_q <= pix;
      p0_r_q   <= r_e;
      p0_c_q   <= c_e;
    end
  end

  mwf_line_store #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .LANES      (LANES)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (c_e),
    .wr_en_i   (s1_go),
    .wr_addr_i (p0_c_q),
    .wr_pix_i  (p0_pix_q),
    .rd_data_o (mem_data)
  );

  mwf_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .LANES      (LANES)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ld_i         (s1_go),
    .pix_i        (p0_pix_q),
    .mem_i        (mem_data),
    .r_i          (p0_r_q),
    .c_i          (p0_c_q),
    .h1_i         (h1),
    .w1_i         (w1),
    .rh_i         (rh),
    .rw_i         (rw),
    .nch_i        (nch),
    .free_o       (free),
    .cand_valid_o (st_valid[0]),
    .cand_val_o   (st_val[0]),
    .cand_act_o   (cand_act),
    .cand_k_o     (cand_k),
    .cand_tag_o   (st_tag[0])
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      st_act[0][l] = cand_act;
      st_k[0][l]   = cand_k;
      st_med[0][l] = '0;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_cell
    mwf_bit_cell #(
      .BIT   (7 - i),
      .LANES (LANES),
      .NV    (NV)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[i]),
      .val_i   (st_val[i]),
      .act_i   (st_act[i]),
      .k_i     (st_k[i]),
      .med_i   (st_med[i]),
      .tag_i   (st_tag[i]),
      .valid_o (st_valid[i+1]),
      .val_o   (st_val[i+1]),
      .act_o   (st_act[i+1]),
      .k_o     (st_k[i+1]),
      .med_o   (st_med[i+1]),
      .tag_o   (st_tag[i+1])
    );
  end

  assign push = en && st_valid[8];
  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      new_med[l] = (l < int'(st_tag[8].nch)) ? st_med[8][l] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q <= sk_valid_q || push;
      sk_valid_q  <= 1'b0;
    end else if (push) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (sk_valid_q) begin
        out_row_q  <= sk_row_q;
        out_col_q  <= sk_col_q;
        out_last_q <= sk_last_q;
        out_med_q  <= sk_med_q;
      end else if (push) begin
        out_row_q  <= st_tag[8].row;
        out_col_q  <= st_tag[8].col[CW-1:0];
        out_last_q <= st_tag[8].last;
        out_med_q  <= new_med;
      end
    end else if (push) begin
      sk_row_q  <= st_tag[8].row;
      sk_col_q  <= st_tag[8].col[CW-1:0];
      sk_last_q <= st_tag[8].last;
      sk_med_q  <= new_med;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_med
    if (k < LANES) begin : g_on
      assign med_port[k] = out_med_q[k];
    end else begin : g_off
      assign med_port[k] = '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign last_of_run_o = out_last_q;
  assign median_0_o    = med_port[0];
  assign median_1_o    = med_port[1];
  assign median_2_o    = med_port[2];

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled while output was free");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p0_valid_q && !s1_go) |=> (p0_valid_q && $stable(p0_c_q)))
    else $error("pending pixel word lost");
`endif

endmodule
`default_nettype wire
